FILE: design/triangle_tangent_frame_unit_assert.svh
// Assertion macros shared by the checker of the triangle tangent frame unit.
// Each macro expands to one labeled concurrent assertion clocked on aclk.
`ifndef TRIANGLE_TANGENT_FRAME_UNIT_ASSERT_SVH
`define TRIANGLE_TANGENT_FRAME_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define TTF_ASSERT_RESET_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ttf_pkg.sv
// Shared widths, constants and types of the triangle tangent frame unit.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ttf_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int POS_W       = 32;
    localparam int DIFF_W      = POS_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int NUM_W       = PROD_W + 1;
    localparam int QUO_W       = POS_W + 1;
    localparam int NSH_W       = NUM_W + FRAC_BITS;
    localparam int HI_W        = NSH_W - QUO_W;
    localparam int CNT_W       = $clog2(QUO_W + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int IN_FIELDS   = 5;
    localparam int OUT_VECS    = 6;
    localparam int SLOT_W      = $clog2(OUT_VECS);
    localparam int IN_W        = IN_FIELDS * POS_W;
    localparam int OUT_W       = OUT_VECS * POS_W;
    localparam int USER_W      = 2;
    localparam int USER_DEGEN  = 0;
    localparam int USER_SAT    = 1;

    localparam logic signed [DIFF_W-1:0] ONE_FLIP = DIFF_W'(1) << FRAC_BITS;
    localparam logic [POS_W-1:0] SAT_POS = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] SAT_NEG = {1'b1, {(POS_W-1){1'b0}}};

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [NUM_W-1:0]  num_t;

    typedef struct packed {
        diff_t [2:0] d1;
        diff_t [2:0] d2;
        diff_t       u1u;
        diff_t       u1v;
        diff_t       u2u;
        diff_t       u2v;
    } tri_t;

    typedef struct packed {
        logic start;
        num_t num;
        num_t den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] value;
        logic             sat;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: design/ttf_front.sv
// Vertex capture: holds the first two vertices of a triangle and, on the third,
// forms the edge and texture differences for the queue. Depends on ttf_pkg.
`default_nettype none

module ttf_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v from the lowest bit up
    input  wire logic [ttf_pkg::IN_W-1:0]  s_tdata,
    input  wire logic                      q_full,
    output logic                           q_push,
    output ttf_pkg::tri_t                  q_data
);

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } phase_t;

    phase_t phase_reg, phase_next;

    ttf_pkg::diff_t p0_reg [3];
    ttf_pkg::diff_t p1_reg [3];
    ttf_pkg::diff_t u0_reg, v0_reg, u1_reg, v1_reg;

    ttf_pkg::diff_t cur_p [3];
    ttf_pkg::diff_t cur_u, cur_v;
    logic           accept, load0, load1;

    assign s_tready = (phase_reg != PH_THIRD) || !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cur_p[k] = {s_tdata[k*ttf_pkg::POS_W + ttf_pkg::POS_W - 1],
                        s_tdata[k*ttf_pkg::POS_W +: ttf_pkg::POS_W]};
        end
        cur_u = {s_tdata[4*ttf_pkg::POS_W - 1], s_tdata[3*ttf_pkg::POS_W +: ttf_pkg::POS_W]};
        cur_v = ttf_pkg::ONE_FLIP -
                {s_tdata[5*ttf_pkg::POS_W - 1], s_tdata[4*ttf_pkg::POS_W +: ttf_pkg::POS_W]};
    end

    always_comb begin
        phase_next = phase_reg;
        q_push     = 1'b0;
        load0      = 1'b0;
        load1      = 1'b0;
        case (phase_reg)
            PH_SECOND: begin
                if (accept) begin
                    load1      = 1'b1;
                    phase_next = PH_THIRD;
                end
            end
            PH_THIRD: begin
                if (accept) begin
                    q_push     = 1'b1;
                    phase_next = PH_FIRST;
                end
            end
            default: begin
                if (accept) begin
                    load0      = 1'b1;
                    phase_next = PH_SECOND;
                end
            end
        endcase
    end

    // The differences of the flipped v coordinates always fit the difference width.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            q_data.d1[k] = p1_reg[k] - p0_reg[k];
            q_data.d2[k] = cur_p[k] - p0_reg[k];
        end
        q_data.u1u = u1_reg - u0_reg;
        q_data.u1v = v1_reg - v0_reg;
        q_data.u2u = cur_u - u0_reg;
        q_data.u2v = cur_v - v0_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
        end else begin
            phase_reg <= phase_next;
        end
        if (load0) begin
            for (int k = 0; k < 3; k++) begin
                p0_reg[k] <= cur_p[k];
            end
            u0_reg <= cur_u;
            v0_reg <= cur_v;
        end
        if (load1) begin
            for (int k = 0; k < 3; k++) begin
                p1_reg[k] <= cur_p[k];
            end
            u1_reg <= cur_u;
            v1_reg <= cur_v;
        end
    end

endmodule

`default_nettype wire

FILE: design/ttf_queue.sv
// Short triangle queue between the vertex front end and the solver back end.
// Depends on ttf_pkg for the triangle record and the queue depth.
`default_nettype none

module ttf_queue (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire ttf_pkg::tri_t push_data,
    output logic         full,
    input  wire logic    pop,
    output ttf_pkg::tri_t pop_data,
    output logic         empty
);

    ttf_pkg::tri_t mem_reg [ttf_pkg::QUEUE_DEPTH];

    logic [ttf_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ttf_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ttf_pkg::QPTR_W:0]   count_reg, count_next;
    logic                       do_push, do_pop;

    assign full     = (count_reg == (ttf_pkg::QPTR_W+1)'(ttf_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + ttf_pkg::QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + ttf_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + (ttf_pkg::QPTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (ttf_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/ttf_div.sv
// Bit-serial restoring divider: signed numerator scaled by the fraction bits over
// a signed determinant, truncated toward zero and saturated. Depends on ttf_pkg.
`default_nettype none

module ttf_div (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire ttf_pkg::div_req_t req,
    output ttf_pkg::div_rsp_t rsp
);

    typedef enum logic [1:0] {
        D_IDLE  = 2'd0,
        D_CHECK = 2'd1,
        D_RUN   = 2'd2,
        D_FIN   = 2'd3
    } dstate_t;

    dstate_t state_reg, state_next;

    logic [ttf_pkg::NUM_W-1:0] nabs_reg, nabs_next;
    logic [ttf_pkg::NUM_W-1:0] dabs_reg, dabs_next;
    logic [ttf_pkg::NUM_W-1:0] rem_reg, rem_next;
    logic [ttf_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [ttf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      neg_reg, neg_next;
    logic                      ovf_reg, ovf_next;

    logic [ttf_pkg::NSH_W-1:0] nsh;
    logic [ttf_pkg::NUM_W-1:0] hi_ext;
    logic [ttf_pkg::NUM_W:0]   trial, trial_diff;
    logic                      sat_pos, sat_neg;

    always_comb begin
        nsh        = {nabs_reg, ttf_pkg::FRAC_BITS'(0)};
        hi_ext     = ttf_pkg::NUM_W'(nsh[ttf_pkg::NSH_W-1:ttf_pkg::QUO_W]);
        trial      = {rem_reg, quo_reg[ttf_pkg::QUO_W-1]};
        trial_diff = trial - {1'b0, dabs_reg};
    end

    always_comb begin
        state_next = state_reg;
        nabs_next  = nabs_reg;
        dabs_next  = dabs_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            D_IDLE: begin
                if (req.start) begin
                    nabs_next  = req.num[ttf_pkg::NUM_W-1] ? ~req.num + 1'b1 : req.num;
                    dabs_next  = req.den[ttf_pkg::NUM_W-1] ? ~req.den + 1'b1 : req.den;
                    neg_next   = req.num[ttf_pkg::NUM_W-1] ^ req.den[ttf_pkg::NUM_W-1];
                    state_next = D_CHECK;
                end
            end
            D_CHECK: begin
                // A high part at or above the divisor means the quotient needs more
                // bits than the result can ever hold.
                if (hi_ext >= dabs_reg) begin
                    ovf_next   = 1'b1;
                    state_next = D_FIN;
                end else begin
                    ovf_next   = 1'b0;
                    rem_next   = hi_ext;
                    quo_next   = nsh[ttf_pkg::QUO_W-1:0];
                    cnt_next   = ttf_pkg::CNT_W'(ttf_pkg::QUO_W);
                    state_next = D_RUN;
                end
            end
            D_RUN: begin
                if (trial >= {1'b0, dabs_reg}) begin
                    rem_next = trial_diff[ttf_pkg::NUM_W-1:0];
                    quo_next = {quo_reg[ttf_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[ttf_pkg::NUM_W-1:0];
                    quo_next = {quo_reg[ttf_pkg::QUO_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - ttf_pkg::CNT_W'(1);
                if (cnt_reg == ttf_pkg::CNT_W'(1)) begin
                    state_next = D_FIN;
                end
            end
            D_FIN: begin
                state_next = D_IDLE;
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_comb begin
        sat_pos = ovf_reg || quo_reg[ttf_pkg::POS_W] || quo_reg[ttf_pkg::POS_W-1];
        sat_neg = ovf_reg || quo_reg[ttf_pkg::POS_W] ||
                  (quo_reg[ttf_pkg::POS_W-1] && (|quo_reg[ttf_pkg::POS_W-2:0]));
        rsp.done = (state_reg == D_FIN);
        if (neg_reg) begin
            rsp.sat   = sat_neg;
            rsp.value = sat_neg ? ttf_pkg::SAT_NEG
                                : ~quo_reg[ttf_pkg::POS_W-1:0] + ttf_pkg::POS_W'(1);
        end else begin
            rsp.sat   = sat_pos;
            rsp.value = sat_pos ? ttf_pkg::SAT_POS : quo_reg[ttf_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
        nabs_reg <= nabs_next;
        dabs_reg <= dabs_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        ovf_reg  <= ovf_next;
    end

endmodule

`default_nettype wire

FILE: design/ttf_back.sv
// Triangle solver: one shared multiplier forms the determinant and the six
// numerators, the divider turns them into the frame. Depends on ttf_pkg.
`default_nettype none

module ttf_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_empty,
    input  wire ttf_pkg::tri_t                q_data,
    output logic                              q_pop,
    output ttf_pkg::div_req_t                 div_req,
    input  wire ttf_pkg::div_rsp_t            div_rsp,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // tangent_x, tangent_y, tangent_z, bitan_x, bitan_y, bitan_z from the lowest bit up
    output logic [ttf_pkg::OUT_W-1:0]         m_tdata,
    // degenerate, saturated from the lowest bit up
    output logic [ttf_pkg::USER_W-1:0]        m_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_MUL_A    = 3'd1,
        ST_MUL_B    = 3'd2,
        ST_SUB      = 3'd3,
        ST_DET      = 3'd4,
        ST_DIV_GO   = 3'd5,
        ST_DIV_WAIT = 3'd6,
        ST_OUT      = 3'd7
    } state_t;

    localparam logic [2:0] PAIR_DET  = 3'd0;
    localparam logic [2:0] PAIR_LAST = 3'd6;

    state_t state_reg, state_next;

    ttf_pkg::tri_t tri_reg, tri_next;
    logic [2:0]    pair_reg, pair_next;
    ttf_pkg::prod_t prod_a_reg, prod_a_next;
    ttf_pkg::prod_t prod_b_reg, prod_b_next;
    ttf_pkg::num_t num_reg, num_next;
    ttf_pkg::num_t det_reg, det_next;
    logic [ttf_pkg::POS_W-1:0] res_reg [ttf_pkg::OUT_VECS];
    logic [ttf_pkg::POS_W-1:0] res_next [ttf_pkg::OUT_VECS];
    logic          degen_reg, degen_next;
    logic          sat_reg, sat_next;

    ttf_pkg::diff_t mul_x, mul_y;
    ttf_pkg::prod_t prod;
    logic [ttf_pkg::SLOT_W-1:0] slot;
    logic           second;

    assign second = (state_reg == ST_MUL_B);

    // Operand pairs: determinant, then tangent and bitangent numerators per axis.
    always_comb begin
        mul_x = tri_reg.u1u;
        mul_y = tri_reg.u2v;
        slot  = ttf_pkg::SLOT_W'(0);
        case (pair_reg)
            3'd1: begin
                mul_x = second ? tri_reg.d2[0] : tri_reg.d1[0];
                mul_y = second ? tri_reg.u1v : tri_reg.u2v;
                slot  = ttf_pkg::SLOT_W'(0);
            end
            3'd2: begin
                mul_x = second ? tri_reg.d1[0] : tri_reg.d2[0];
                mul_y = second ? tri_reg.u2u : tri_reg.u1u;
                slot  = ttf_pkg::SLOT_W'(3);
            end
            3'd3: begin
                mul_x = second ? tri_reg.d2[1] : tri_reg.d1[1];
                mul_y = second ? tri_reg.u1v : tri_reg.u2v;
                slot  = ttf_pkg::SLOT_W'(1);
            end
            3'd4: begin
                mul_x = second ? tri_reg.d1[1] : tri_reg.d2[1];
                mul_y = second ? tri_reg.u2u : tri_reg.u1u;
                slot  = ttf_pkg::SLOT_W'(4);
            end
            3'd5: begin
                mul_x = second ? tri_reg.d2[2] : tri_reg.d1[2];
                mul_y = second ? tri_reg.u1v : tri_reg.u2v;
                slot  = ttf_pkg::SLOT_W'(2);
            end
            3'd6: begin
                mul_x = second ? tri_reg.d1[2] : tri_reg.d2[2];
                mul_y = second ? tri_reg.u2u : tri_reg.u1u;
                slot  = ttf_pkg::SLOT_W'(5);
            end
            default: begin
                mul_x = second ? tri_reg.u1v : tri_reg.u1u;
                mul_y = second ? tri_reg.u2u : tri_reg.u2v;
            end
        endcase
    end

    assign prod = mul_x * mul_y;

    always_comb begin
        state_next  = state_reg;
        tri_next    = tri_reg;
        pair_next   = pair_reg;
        prod_a_next = prod_a_reg;
        prod_b_next = prod_b_reg;
        num_next    = num_reg;
        det_next    = det_reg;
        degen_next  = degen_reg;
        sat_next    = sat_reg;
        for (int k = 0; k < ttf_pkg::OUT_VECS; k++) begin
            res_next[k] = res_reg[k];
        end
        q_pop = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    tri_next   = q_data;
                    pair_next  = PAIR_DET;
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                prod_a_next = prod;
                state_next  = ST_MUL_B;
            end
            ST_MUL_B: begin
                prod_b_next = prod;
                state_next  = ST_SUB;
            end
            ST_SUB: begin
                num_next   = ttf_pkg::NUM_W'(prod_a_reg) - ttf_pkg::NUM_W'(prod_b_reg);
                state_next = (pair_reg == PAIR_DET) ? ST_DET : ST_DIV_GO;
            end
            ST_DET: begin
                det_next = num_reg;
                sat_next = 1'b0;
                if (num_reg == '0) begin
                    degen_next = 1'b1;
                    for (int k = 0; k < ttf_pkg::OUT_VECS; k++) begin
                        res_next[k] = '0;
                    end
                    state_next = ST_OUT;
                end else begin
                    degen_next = 1'b0;
                    pair_next  = pair_reg + 3'd1;
                    state_next = ST_MUL_A;
                end
            end
            ST_DIV_GO: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    res_next[slot] = div_rsp.value;
                    sat_next       = sat_reg | div_rsp.sat;
                    if (pair_reg == PAIR_LAST) begin
                        state_next = ST_OUT;
                    end else begin
                        pair_next  = pair_reg + 3'd1;
                        state_next = ST_MUL_A;
                    end
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        div_req.start = (state_reg == ST_DIV_GO);
        div_req.num   = num_reg;
        div_req.den   = det_reg;
    end

    assign m_tvalid = (state_reg == ST_OUT);

    always_comb begin
        for (int k = 0; k < ttf_pkg::OUT_VECS; k++) begin
            m_tdata[k*ttf_pkg::POS_W +: ttf_pkg::POS_W] = res_reg[k];
        end
        m_tuser[ttf_pkg::USER_DEGEN] = degen_reg;
        m_tuser[ttf_pkg::USER_SAT]   = sat_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        tri_reg    <= tri_next;
        pair_reg   <= pair_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        num_reg    <= num_next;
        det_reg    <= det_next;
        degen_reg  <= degen_next;
        sat_reg    <= sat_next;
        for (int k = 0; k < ttf_pkg::OUT_VECS; k++) begin
            res_reg[k] <= res_next[k];
        end
    end

endmodule

`default_nettype wire

FILE: design/triangle_tangent_frame_unit.sv
// Top level of the triangle tangent frame unit: vertex front end, triangle queue,
// solver back end and shared divider. Depends on ttf_pkg and the ttf_ modules.
//
// Usage: vertices arrive on the s_ stream, one per beat, and every three beats
// form one triangle. The third beat of each triangle produces exactly one result
// beat on the m_ stream with the tangent, the bitangent and two flags in tuser.
// s_tready stays high for the first two vertices of a triangle, and for the
// third as long as the two-entry triangle queue has room.
// From the third vertex the result follows these steps: the triangle is taken
// from the queue, the determinant is formed on the multiplier, then for each of
// the six components two products and their difference, and a division in the
// one-bit-per-cycle divider. A component whose quotient is far out of range
// skips the bit-serial steps of the divider. The back end solves one triangle at
// a time and takes the next from the queue only after its result beat is taken.
// A zero determinant skips the divisions and gives an all-zero degenerate result.
// A stalled result beat holds its data; the front end keeps taking vertices
// until the queue fills, then holds s_tready low on the third vertex.
// Reset clears the vertex phase, the queue and the result valid.
`default_nettype none

module triangle_tangent_frame_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v from the lowest bit up
    input  wire logic [ttf_pkg::IN_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // tangent_x, tangent_y, tangent_z, bitan_x, bitan_y, bitan_z from the lowest bit up
    output logic [ttf_pkg::OUT_W-1:0]          m_tdata,
    // degenerate, saturated from the lowest bit up
    output logic [ttf_pkg::USER_W-1:0]         m_tuser
);

    logic              q_push, q_full, q_pop, q_empty;
    ttf_pkg::tri_t     q_in, q_out;
    ttf_pkg::div_req_t div_req;
    ttf_pkg::div_rsp_t div_rsp;

    ttf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    ttf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    ttf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ttf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

endmodule

`default_nettype wire

FILE: design/ttf_checker.sv
// Port-level checker of the triangle tangent frame unit and its bind statement.
// Depends on ttf_pkg and triangle_tangent_frame_unit_assert.svh.
`default_nettype none

`include "triangle_tangent_frame_unit_assert.svh"

module ttf_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    // tangent_x, tangent_y, tangent_z, bitan_x, bitan_y, bitan_z from the lowest bit up
    input wire logic [ttf_pkg::OUT_W-1:0]     m_tdata,
    // degenerate, saturated from the lowest bit up
    input wire logic [ttf_pkg::USER_W-1:0]    m_tuser
);

    logic any_clip;

    always_comb begin
        any_clip = 1'b0;
        for (int k = 0; k < ttf_pkg::OUT_VECS; k++) begin
            if (m_tdata[k*ttf_pkg::POS_W +: ttf_pkg::POS_W] == ttf_pkg::SAT_POS ||
                m_tdata[k*ttf_pkg::POS_W +: ttf_pkg::POS_W] == ttf_pkg::SAT_NEG) begin
                any_clip = 1'b1;
            end
        end
    end

    `TTF_ASSERT_RESET_NEXT(a_reset_clears_valid, !aresetn, !m_tvalid, "result valid after reset")
    `TTF_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `TTF_ASSERT_NOW(a_degen_zero, m_tvalid && m_tuser[ttf_pkg::USER_DEGEN], m_tdata == '0 && !m_tuser[ttf_pkg::USER_SAT], "degenerate result not zero")
    `TTF_ASSERT_NOW(a_sat_clips, m_tvalid && m_tuser[ttf_pkg::USER_SAT], any_clip, "saturated result without clipped component")

endmodule

bind triangle_tangent_frame_unit ttf_checker u_ttf_checker (.*);

`default_nettype wire
